@@ hdl/cts_pkg.sv @@
// Package for the compact target scaler: field widths, masks and the
// stage record passed from the multiply stage to the finishing stage.
// No dependencies.
package cts_pkg;

  localparam int LenW  = 8;
  localparam int MantW = 24;
  localparam int WordW = 32;
  localparam int ProdW = 64;
  localparam int FracW = 24;

  localparam logic [WordW-1:0] MAX_COMPACT_RESET = 32'h1d00_ffff;

  // Length and scaled mantissa after the multiply, before renormalizing.
  typedef struct packed {
    logic             valid;
    logic [LenW-1:0]  len;
    logic [WordW-1:0] mant;
  } prod_stage_t;

endpackage

@@ hdl/compact_target_scale.sv @@
// Compact target scaler: scales a compact target (8-bit length, 24-bit
// mantissa) by an unsigned Q8.24 factor, clamps it to max_compact and pads
// a mantissa whose top bit is set. An item is taken on any cycle with start
// high; busy is never raised, so one item enters per cycle. The result
// appears with a one-cycle done strobe after passing through an input
// register, a register after the 32x32 multiplier, and the result register.
// The receiver cannot stall the output. Write max_compact only when no items
// are in flight. Depends on cts_pkg, cts_mult and cts_finish.
module compact_target_scale
  import cts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [WordW-1:0] compact_in,
  input  logic [WordW-1:0] factor,
  input  logic             max_compact_we,
  input  logic [WordW-1:0] max_compact_wdata,
  output logic             done,
  output logic [WordW-1:0] compact_out
);

  logic [WordW-1:0] max_compact;
  prod_stage_t      prod;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_compact <= MAX_COMPACT_RESET;
    end else if (max_compact_we) begin
      max_compact <= max_compact_wdata;
    end
  end

  cts_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .compact_in (compact_in),
    .factor     (factor),
    .prod       (prod)
  );

  cts_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .prod        (prod),
    .max_compact (max_compact),
    .done        (done),
    .compact_out (compact_out)
  );

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (rst) start |-> ##3 done)
    else $error("item accepted without a result three cycles later");
  a_no_extra : assert property (@(posedge clk) disable iff (rst) done |-> $past(start, 3))
    else $error("result strobe without a matching item");
  a_padded : assert property (@(posedge clk) disable iff (rst) done |-> !compact_out[MantW-1])
    else $error("result mantissa has its top bit set after padding");
`endif

endmodule

@@ hdl/cts_mult.sv @@
// Input register and multiply stage of the compact target scaler.
// Depends on cts_pkg.
module cts_mult
  import cts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WordW-1:0] compact_in,
  input  logic [WordW-1:0] factor,
  output prod_stage_t      prod
);

  logic             in_valid;
  logic [LenW-1:0]  in_len;
  logic [MantW-1:0] in_mant;
  logic [WordW-1:0] in_factor;

  logic             below_one;
  logic [WordW-1:0] oper;
  logic [ProdW-1:0] full_prod;
  prod_stage_t      prod_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    in_len    <= compact_in[WordW-1:MantW];
    in_mant   <= compact_in[MantW-1:0];
    in_factor <= factor;
  end

  // A factor below one moves the mantissa up a byte first, so the
  // truncation keeps eight more bits of precision.
  always_comb begin
    below_one = (in_factor[WordW-1:FracW] == '0);
    oper      = below_one ? {in_mant, 8'h00} : {8'h00, in_mant};
    full_prod = ProdW'(oper) * ProdW'(in_factor);
    prod_next.valid = in_valid;
    prod_next.len   = below_one ? in_len - 8'd1 : in_len;
    prod_next.mant  = full_prod[FracW+WordW-1:FracW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else begin
      prod.valid <= prod_next.valid;
    end
    prod.len  <= prod_next.len;
    prod.mant <= prod_next.mant;
  end

endmodule

@@ hdl/cts_finish.sv @@
// Finishing stage of the compact target scaler: renormalize, clamp to the
// configured maximum, pad, and register the result. Depends on cts_pkg.
module cts_finish
  import cts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  prod_stage_t      prod,
  input  logic [WordW-1:0] max_compact,
  output logic             done,
  output logic [WordW-1:0] compact_out
);

  logic [LenW-1:0]  max_len;
  logic [MantW-1:0] max_mant;
  logic [LenW-1:0]  norm_len;
  logic [MantW-1:0] norm_mant;
  logic [LenW-1:0]  clamp_len;
  logic [MantW-1:0] clamp_mant;
  logic [WordW-1:0] compact_next;

  always_comb begin
    max_len  = max_compact[WordW-1:MantW];
    max_mant = max_compact[MantW-1:0];

    if (prod.mant[WordW-1:MantW] != '0) begin
      norm_len  = prod.len + 8'd1;
      norm_mant = prod.mant[WordW-1:8];
    end else begin
      norm_len  = prod.len;
      norm_mant = prod.mant[MantW-1:0];
    end

    if ((max_len < norm_len) || ((max_len == norm_len) && (max_mant < norm_mant))) begin
      clamp_len  = max_len;
      clamp_mant = max_mant;
    end else begin
      clamp_len  = norm_len;
      clamp_mant = norm_mant;
    end

    // A set top mantissa bit would read as a sign, so move it down a byte.
    if (clamp_mant[MantW-1]) begin
      compact_next = {clamp_len + 8'd1, 8'h00, clamp_mant[MantW-1:8]};
    end else begin
      compact_next = {clamp_len, clamp_mant};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod.valid;
    end
    compact_out <= compact_next;
  end

endmodule

@@ tb/compact_target_scale_tb.sv @@
// Testbench for compact_target_scale: drives compact targets and Q8.24 factors,
// predicts each scaled, clamped and padded target, and checks every result.
// Depends on cts_pkg and the compact_target_scale RTL.
`timescale 1ns / 100ps

module compact_target_scale_tb;
  import cts_pkg::*;

  localparam logic [WordW-1:0] FACTOR_ONE = 32'h0100_0000;
  localparam int NUM_SETTINGS = 6;
  localparam int ITEMS_PER_SETTING = 108;

  typedef struct packed {
    logic [WordW-1:0] compact;
    logic [WordW-1:0] factor;
  } scale_item_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [WordW-1:0] compact_in = '0;
  logic [WordW-1:0] factor = '0;
  logic             max_compact_we = 1'b0;
  logic [WordW-1:0] max_compact_wdata = '0;
  logic             done;
  logic [WordW-1:0] compact_out;

  scale_item_t      target_q[$];
  logic [WordW-1:0] expected_q[$];
  logic [WordW-1:0] max_compact_copy = MAX_COMPACT_RESET;
  int               send_idle_pct = 25;
  int               n_items = 0;
  int               n_checked = 0;
  int               n_clamped = 0;
  int               n_padded = 0;
  int               n_errors = 0;

  compact_target_scale u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .compact_in       (compact_in),
    .factor           (factor),
    .max_compact_we   (max_compact_we),
    .max_compact_wdata(max_compact_wdata),
    .done             (done),
    .compact_out      (compact_out)
  );

  always #2 clk = ~clk;

  function automatic logic [WordW-1:0] predict_compact(
    input  logic [WordW-1:0] cin,
    input  logic [WordW-1:0] fac,
    input  logic [WordW-1:0] max_word,
    output logic             clamped,
    output logic             padded
  );
    logic [LenW-1:0]  len;
    logic [WordW-1:0] mant;
    logic [ProdW-1:0] wide_mant;
    logic [ProdW-1:0] prod;
    len = cin[31:24];
    wide_mant = {40'd0, cin[23:0]};
    // A factor below one borrows a byte of length to keep precision.
    if (fac < FACTOR_ONE) begin
      len = len - 8'd1;
      wide_mant = wide_mant << 8;
    end
    prod = wide_mant * {32'd0, fac};
    mant = prod[55:24];
    if (mant[31:24] != 8'd0) begin
      len = len + 8'd1;
      mant = mant >> 8;
    end
    clamped = (max_word[31:24] < len) ||
              (max_word[31:24] == len && {8'd0, max_word[23:0]} < mant);
    if (clamped) begin
      len = max_word[31:24];
      mant = {8'd0, max_word[23:0]};
    end
    padded = mant[23];
    if (padded) begin
      len = len + 8'd1;
      mant = mant >> 8;
    end
    return {len, mant[23:0]};
  endfunction

  // Random targets are pulled toward the configured maximum so that the
  // clamp and its boundaries are hit often.
  function automatic scale_item_t random_target(input logic [WordW-1:0] max_word);
    scale_item_t item;
    logic [LenW-1:0]  len;
    logic [MantW-1:0] mant;
    case ($urandom_range(0, 3))
      0: len = max_word[31:24];
      1: len = max_word[31:24] + 8'd1;
      2: len = max_word[31:24] - 8'd1;
      default: len = LenW'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 4))
      0: mant = max_word[23:0] + 24'($urandom_range(0, 4)) - 24'd2;
      1: mant = 24'h80_0000 | 24'($urandom);
      2: mant = 24'($urandom_range(0, 255));
      default: mant = 24'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: item.factor = $urandom_range(0, 32'h00ff_ffff);
      1: item.factor = $urandom_range(32'h00ff_0000, 32'h0100_ffff);
      2: item.factor = $urandom_range(32'h0100_0000, 32'h0400_0000);
      default: item.factor = $urandom;
    endcase
    item.compact = {len, mant};
    return item;
  endfunction

  // Sender: holds an item while busy, otherwise loads the next one or idles.
  always @(posedge clk) begin : drive_proc
    scale_item_t      item;
    logic [WordW-1:0] want;
    logic             clamped;
    logic             padded;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        want = predict_compact(compact_in, factor, max_compact_copy, clamped, padded);
        expected_q.push_back(want);
        n_items++;
        n_clamped += clamped;
        n_padded += padded;
      end
      if (!start || !busy) begin
        if (target_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item = target_q.pop_front();
          start <= 1'b1;
          compact_in <= item.compact;
          factor <= item.factor;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_proc
    logic [WordW-1:0] want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with no item pending: expected none, got %08h",
                 $time, compact_out);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (compact_out !== want) begin
          $display("%0t: compact_out mismatch: expected %08h, got %08h",
                   $time, want, compact_out);
          n_errors++;
        end
      end
    end
  end

  // Polls on the falling edge so the driver's updates have settled.
  task automatic wait_idle(input int limit);
    int cycles;
    cycles = 0;
    @(negedge clk);
    while ((target_q.size() != 0 || start || expected_q.size() != 0) && cycles < limit) begin
      @(negedge clk);
      cycles++;
    end
  endtask

  task automatic write_max_compact(input logic [WordW-1:0] value);
    @(posedge clk);
    max_compact_we <= 1'b1;
    max_compact_wdata <= value;
    @(posedge clk);
    max_compact_we <= 1'b0;
    max_compact_copy = value;
  endtask

  task automatic push_target(input logic [WordW-1:0] cin, input logic [WordW-1:0] fac);
    scale_item_t item;
    item.compact = cin;
    item.factor = fac;
    target_q.push_back(item);
  endtask

  initial begin
    logic [WordW-1:0] settings[NUM_SETTINGS];
    settings[0] = MAX_COMPACT_RESET;
    settings[1] = 32'hffff_ffff;
    settings[2] = 32'h0000_0000;
    settings[3] = $urandom;
    settings[4] = MAX_COMPACT_RESET;
    settings[5] = 32'h0480_0000;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed targets under the reset maximum.
    push_target(32'h0000_0000, 32'h0000_0000);
    push_target(32'hffff_ffff, 32'hffff_ffff);
    push_target(32'h1d00_ffff, FACTOR_ONE);
    push_target(32'h1d01_0000, FACTOR_ONE);
    push_target(32'h1e00_0001, FACTOR_ONE);
    push_target(32'h1c7f_ffff, 32'h0200_0000);
    push_target(32'h1c80_0000, 32'h0200_0000);
    push_target(32'h1080_0000, FACTOR_ONE);
    push_target(32'h1234_5678, 32'h0080_0000);
    push_target(32'h1234_5678, 32'h00ff_ffff);
    push_target(32'h1234_5678, 32'h0000_0001);
    push_target(32'h00ff_ffff, 32'h0080_0000);
    push_target(32'h0000_0001, 32'h0000_0001);
    push_target(32'hff80_0000, 32'h0200_0000);
    push_target(32'h05ff_ffff, 32'hffff_ffff);
    push_target(32'h1d00_ffff, 32'h00ff_ffff);
    push_target(32'h1b00_ffff, 32'hff00_0000);
    push_target(32'h1c00_0000, 32'h0000_0000);
    push_target(32'h0000_8000, 32'h0000_0000);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s != 0) begin
        wait_idle(200000);
        repeat (4) @(posedge clk);
        write_max_compact(settings[s]);
      end
      send_idle_pct = (s < 2) ? 25 : (s < 4) ? 82 : 0;
      for (int i = 0; i < ITEMS_PER_SETTING; i++)
        target_q.push_back(random_target(max_compact_copy));
    end

    wait_idle(2000);
    repeat (6) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived: expected %08h, got none",
               $time, expected_q.size(), expected_q[0]);
      n_errors++;
    end

    $display("Scaled %0d targets under %0d max_compact settings, %0d results checked.",
             n_items, NUM_SETTINGS, n_checked);
    $display("Of those, %0d were clamped to the maximum and %0d were padded.",
             n_clamped, n_padded);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("Verification failed");
    $finish;
  end

endmodule

@@ compact_target_scale.f @@
hdl/cts_pkg.sv
hdl/cts_mult.sv
hdl/cts_finish.sv
hdl/compact_target_scale.sv
tb/compact_target_scale_tb.sv
